// ----- design/mppt_pkg.sv -----
// types, constants and codes shared by the tracker controller, datapath and top level
package mppt_pkg;

   localparam int CODE_W     = 12;
   localparam int STEP_W     = 11;
   localparam int SWEEP_W    = 13;
   localparam int POINTS_W   = 7;
   localparam int SLOPE_W    = 24;
   localparam int OFFSET_W   = 32;
   localparam int CAL_W      = 37;
   localparam int HALF_W     = 18;
   localparam int PART_W     = 20;
   localparam int PROD_W     = 40;
   localparam int ACC_W      = 75;
   localparam int PWR_W      = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CODE_W-1:0]   DAC_MAX     = 12'd4095;
   localparam logic [POINTS_W-1:0] MAX_POINTS  = 7'd100;
   localparam logic [CODE_W-1:0]   ANCHOR_BAND = 12'd3;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_SWEEP  = 2'd1;
   localparam logic [1:0] OP_TRACK  = 2'd2;

   localparam logic [1:0] MUL_HH = 2'd0;
   localparam logic [1:0] MUL_HL = 2'd1;
   localparam logic [1:0] MUL_LH = 2'd2;
   localparam logic [1:0] MUL_LL = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_ADC_SLOPE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ADC_OFFSET  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DAC_SLOPE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DAC_OFFSET  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TRACK_STEP  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SWEEP_START = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SWEEP_STEP  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SWEEP_PTS   = 3'd7;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_TRACK = 2'd1,
      MODE_SWEEP = 2'd2
   } run_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CAL,
      ST_MUL,
      ST_UPD
   } ctrl_state_type;

   typedef struct packed {
      logic       load;
      logic       calib;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic       update;
   } dp_cmd_type;

endpackage

// ----- design/mppt_ctrl.sv -----
// sequencer for the tracker: request accept, calibration, four multiply passes, update
module mppt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mppt_pkg::dp_cmd_type cmd
);

   mppt_pkg::ctrl_state_type state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mppt_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         mppt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = mppt_pkg::ST_CAL;
            end
         end
         mppt_pkg::ST_CAL: begin
            cmd.calib = 1'b1;
            cnt_in    = mppt_pkg::MUL_HH;
            state_in  = mppt_pkg::ST_MUL;
         end
         mppt_pkg::ST_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = cnt_ff;
            cnt_in      = cnt_ff + 2'd1;
            if (cnt_ff == mppt_pkg::MUL_LL) begin
               state_in = mppt_pkg::ST_UPD;
            end
         end
         mppt_pkg::ST_UPD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.update   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = mppt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mppt_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- design/mppt_dp.sv -----
// tracker datapath: settings, calibration, split power multiply, tracking and sweep state
module mppt_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [mppt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mppt_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [1:0]                           req_opcode,
   input  logic [mppt_pkg::CODE_W-1:0]          req_current_code,
   input  mppt_pkg::dp_cmd_type                 cmd,
   output logic [mppt_pkg::CODE_W-1:0]          rsp_dac_code,
   output logic [mppt_pkg::CODE_W-1:0]          rsp_point_code,
   output logic signed [mppt_pkg::PWR_W-1:0]    rsp_power,
   output logic                                 rsp_direction_down,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_sweep_last
);

   localparam int CW = mppt_pkg::CODE_W;

   // settings
   logic signed [mppt_pkg::SLOPE_W-1:0]  adc_slope_ff, dac_slope_ff;
   logic signed [mppt_pkg::OFFSET_W-1:0] adc_offset_ff, dac_offset_ff;
   logic [mppt_pkg::STEP_W-1:0]          track_step_ff;
   logic [CW-1:0]                        sweep_start_ff;
   logic signed [mppt_pkg::SWEEP_W-1:0]  sweep_step_ff;
   logic [mppt_pkg::POINTS_W-1:0]        sweep_pts_ff;

   // tracker state
   mppt_pkg::run_mode_type               mode_ff, mode_in;
   logic [CW-1:0]                        code_ff, code_in;
   logic                                 down_ff, down_in;
   logic signed [mppt_pkg::PWR_W-1:0]    prev_ff, prev_in;
   logic [CW-1:0]                        anchor_ff, anchor_in;
   logic [mppt_pkg::POINTS_W-1:0]        pts_ff, pts_in;

   // working registers
   logic [1:0]                           op_ff;
   logic [CW-1:0]                        cc_ff;
   logic signed [mppt_pkg::CAL_W-1:0]    cur_ff, vol_ff, cur_in, vol_in;
   logic signed [mppt_pkg::ACC_W-1:0]    acc_ff, acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         adc_slope_ff   <= 24'sd1;
         adc_offset_ff  <= '0;
         dac_slope_ff   <= 24'sd1;
         dac_offset_ff  <= '0;
         track_step_ff  <= 11'd10;
         sweep_start_ff <= '0;
         sweep_step_ff  <= '0;
         sweep_pts_ff   <= mppt_pkg::MAX_POINTS;
      end else if (csr_write_en) begin
         case (csr_index)
            mppt_pkg::REG_ADC_SLOPE:   adc_slope_ff   <= csr_wdata[mppt_pkg::SLOPE_W-1:0];
            mppt_pkg::REG_ADC_OFFSET:  adc_offset_ff  <= csr_wdata;
            mppt_pkg::REG_DAC_SLOPE:   dac_slope_ff   <= csr_wdata[mppt_pkg::SLOPE_W-1:0];
            mppt_pkg::REG_DAC_OFFSET:  dac_offset_ff  <= csr_wdata;
            mppt_pkg::REG_TRACK_STEP:  track_step_ff  <= csr_wdata[mppt_pkg::STEP_W-1:0];
            mppt_pkg::REG_SWEEP_START: sweep_start_ff <= csr_wdata[CW-1:0];
            mppt_pkg::REG_SWEEP_STEP:  sweep_step_ff  <= csr_wdata[mppt_pkg::SWEEP_W-1:0];
            mppt_pkg::REG_SWEEP_PTS:   sweep_pts_ff   <= csr_wdata[mppt_pkg::POINTS_W-1:0];
            default: ;
         endcase
      end
   end

   // calibration to nanoamps and microvolts
   logic signed [mppt_pkg::CAL_W-1:0] cc_s, code_s;
   assign cc_s   = mppt_pkg::CAL_W'($signed({1'b0, cc_ff}));
   assign code_s = mppt_pkg::CAL_W'($signed({1'b0, code_ff}));
   assign cur_in = cc_s * mppt_pkg::CAL_W'(adc_slope_ff) + mppt_pkg::CAL_W'(adc_offset_ff);
   assign vol_in = code_s * mppt_pkg::CAL_W'(dac_slope_ff) + mppt_pkg::CAL_W'(dac_offset_ff);

   // one 20x20 partial product per cycle
   logic signed [mppt_pkg::PART_W-1:0] cur_hi, cur_lo, vol_hi, vol_lo, mul_a, mul_b;
   logic signed [mppt_pkg::PROD_W-1:0] prod;
   logic signed [mppt_pkg::ACC_W-1:0]  prod_ext, prod_sh;

   assign cur_hi = mppt_pkg::PART_W'($signed(cur_ff[mppt_pkg::CAL_W-1:mppt_pkg::HALF_W]));
   assign vol_hi = mppt_pkg::PART_W'($signed(vol_ff[mppt_pkg::CAL_W-1:mppt_pkg::HALF_W]));
   assign cur_lo = $signed({2'b00, cur_ff[mppt_pkg::HALF_W-1:0]});
   assign vol_lo = $signed({2'b00, vol_ff[mppt_pkg::HALF_W-1:0]});
   assign mul_a  = cmd.mul_sel[1] ? cur_lo : cur_hi;
   assign mul_b  = cmd.mul_sel[0] ? vol_lo : vol_hi;
   assign prod   = mppt_pkg::PROD_W'(mul_a) * mppt_pkg::PROD_W'(mul_b);
   assign prod_ext = mppt_pkg::ACC_W'(prod);

   always_comb begin
      case (cmd.mul_sel)
         mppt_pkg::MUL_HH: prod_sh = prod_ext <<< (2 * mppt_pkg::HALF_W);
         mppt_pkg::MUL_HL: prod_sh = prod_ext <<< mppt_pkg::HALF_W;
         mppt_pkg::MUL_LH: prod_sh = prod_ext <<< mppt_pkg::HALF_W;
         default:          prod_sh = prod_ext;
      endcase
   end

   assign acc_in = acc_ff + prod_sh;

   // saturate to 64 bits
   logic signed [mppt_pkg::PWR_W-1:0] pw_sat;
   logic [mppt_pkg::ACC_W-mppt_pkg::PWR_W:0] top_bits;
   assign top_bits = acc_ff[mppt_pkg::ACC_W-1:mppt_pkg::PWR_W-1];

   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         pw_sat = acc_ff[mppt_pkg::PWR_W-1:0];
      end else if (acc_ff[mppt_pkg::ACC_W-1]) begin
         pw_sat = {1'b1, {(mppt_pkg::PWR_W-1){1'b0}}};
      end else begin
         pw_sat = {1'b0, {(mppt_pkg::PWR_W-1){1'b1}}};
      end
   end

   // tracking step
   logic signed [CW:0]   diff;
   logic [CW-1:0]        diff_abs;
   logic                 flip, dir1;
   logic [CW:0]          down_sum, up_sum;
   logic [CW-1:0]        trk_code;
   logic                 trk_dir;

   assign diff     = $signed({1'b0, cc_ff}) - $signed({1'b0, anchor_ff});
   assign diff_abs = diff[CW] ? CW'(-diff) : diff[CW-1:0];
   assign flip     = !((pw_sat >= prev_ff) || (diff_abs < mppt_pkg::ANCHOR_BAND));
   assign dir1     = down_ff ^ flip;
   assign down_sum = {1'b0, code_ff} - (CW+1)'(track_step_ff);
   assign up_sum   = {1'b0, code_ff} + (CW+1)'(track_step_ff);

   always_comb begin
      if (dir1) begin
         if (down_sum[CW]) begin
            trk_code = {track_step_ff, 1'b0};
            trk_dir  = ~dir1;
         end else begin
            trk_code = down_sum[CW-1:0];
            trk_dir  = dir1;
         end
      end else begin
         if (up_sum > (CW+1)'(mppt_pkg::DAC_MAX)) begin
            trk_code = mppt_pkg::DAC_MAX;
            trk_dir  = ~dir1;
         end else begin
            trk_code = up_sum[CW-1:0];
            trk_dir  = dir1;
         end
      end
   end

   // sweep step
   logic [mppt_pkg::POINTS_W-1:0] n_pts, pts_inc;
   logic signed [CW+1:0]          sw_sum;
   logic [CW-1:0]                 sw_code;

   always_comb begin
      if (sweep_pts_ff > mppt_pkg::MAX_POINTS) begin
         n_pts = mppt_pkg::MAX_POINTS;
      end else if (sweep_pts_ff == '0) begin
         n_pts = mppt_pkg::POINTS_W'(1);
      end else begin
         n_pts = sweep_pts_ff;
      end
   end

   assign pts_inc = pts_ff + mppt_pkg::POINTS_W'(1);
   assign sw_sum  = $signed({2'b00, code_ff}) + (CW+2)'(sweep_step_ff);

   always_comb begin
      if (sw_sum < 0) begin
         sw_code = '0;
      end else if (sw_sum > $signed({2'b00, mppt_pkg::DAC_MAX})) begin
         sw_code = mppt_pkg::DAC_MAX;
      end else begin
         sw_code = sw_sum[CW-1:0];
      end
   end

   // next state and result
   logic [CW-1:0]                     point_v;
   logic signed [mppt_pkg::PWR_W-1:0] pw_v;
   logic                              last_v;

   always_comb begin
      mode_in   = mode_ff;
      code_in   = code_ff;
      down_in   = down_ff;
      prev_in   = prev_ff;
      anchor_in = anchor_ff;
      pts_in    = pts_ff;
      point_v   = code_ff;
      pw_v      = '0;
      last_v    = 1'b0;
      case (op_ff)
         mppt_pkg::OP_SAMPLE: begin
            if (mode_ff == mppt_pkg::MODE_TRACK) begin
               pw_v      = pw_sat;
               prev_in   = pw_sat;
               anchor_in = flip ? cc_ff : anchor_ff;
               code_in   = trk_code;
               down_in   = trk_dir;
            end else if (mode_ff == mppt_pkg::MODE_SWEEP) begin
               pw_v   = pw_sat;
               pts_in = pts_inc;
               if (pts_inc >= n_pts) begin
                  mode_in = mppt_pkg::MODE_IDLE;
                  last_v  = 1'b1;
               end else begin
                  code_in = sw_code;
               end
            end
         end
         mppt_pkg::OP_SWEEP: begin
            mode_in = mppt_pkg::MODE_SWEEP;
            pts_in  = '0;
            code_in = sweep_start_ff;
            point_v = '0;
         end
         mppt_pkg::OP_TRACK: begin
            mode_in = mppt_pkg::MODE_TRACK;
            point_v = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= mppt_pkg::MODE_TRACK;
         code_ff   <= '0;
         down_ff   <= 1'b1;
         prev_ff   <= '0;
         anchor_ff <= '0;
         pts_ff    <= '0;
      end else if (cmd.update) begin
         mode_ff   <= mode_in;
         code_ff   <= code_in;
         down_ff   <= down_in;
         prev_ff   <= prev_in;
         anchor_ff <= anchor_in;
         pts_ff    <= pts_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_opcode;
         cc_ff <= req_current_code;
      end
      if (cmd.calib) begin
         cur_ff <= cur_in;
         vol_ff <= vol_in;
         acc_ff <= '0;
      end else if (cmd.mul_en) begin
         acc_ff <= acc_in;
      end
      if (cmd.update) begin
         rsp_dac_code       <= code_in;
         rsp_point_code     <= point_v;
         rsp_power          <= pw_v;
         rsp_direction_down <= down_in;
         rsp_busy_res       <= (mode_in == mppt_pkg::MODE_SWEEP);
         rsp_sweep_last     <= last_v;
      end
   end

endmodule

// ----- design/mppt_perturb_observe_with_iv_sweep_unit.sv -----
// Perturb-and-observe MPPT with I-V sweep: one response for every request, one request in
// flight at a time. After the accept step, a request goes through one calibration step,
// four passes through the shared 20x20 multiplier that build the 37x37-bit power product,
// and one update step before the block is ready again. If the previous response
// has not yet been taken, the update step waits for it. Settings written through the csr
// port take effect on the next request if written while idle; the block does not enforce it.
module mppt_perturb_observe_with_iv_sweep_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [mppt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mppt_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_opcode,
   input  logic [mppt_pkg::CODE_W-1:0]        req_current_code,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mppt_pkg::CODE_W-1:0]        rsp_dac_code,
   output logic [mppt_pkg::CODE_W-1:0]        rsp_point_code,
   output logic signed [mppt_pkg::PWR_W-1:0]  rsp_power,
   output logic                               rsp_direction_down,
   output logic                               rsp_busy_res,
   output logic                               rsp_sweep_last
);

   mppt_pkg::dp_cmd_type cmd;

   mppt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   mppt_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_opcode         (req_opcode),
      .req_current_code   (req_current_code),
      .cmd                (cmd),
      .rsp_dac_code       (rsp_dac_code),
      .rsp_point_code     (rsp_point_code),
      .rsp_power          (rsp_power),
      .rsp_direction_down (rsp_direction_down),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_sweep_last     (rsp_sweep_last)
   );

   // one request at a time
   a_single_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   // a response is pending once the request has gone through the datapath
   a_response_due: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##7 rsp_valid)
      else $error("no response after request");

   // the final sweep point leaves the sweep finished
   a_last_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sweep_last |-> !rsp_busy_res)
      else $error("sweep still busy on its final point");

   // every calibration is followed by the first multiply pass, the high-high partial product
   a_mul_after_cal: assert property (@(posedge clock) disable iff (reset)
      cmd.calib |=> cmd.mul_en && (cmd.mul_sel == mppt_pkg::MUL_HH))
      else $error("multiply sequence did not follow calibration");

endmodule
